// File: design/thermal_pixel_radiometric_map_macros.svh
// Assertion macros shared by the radiometric map RTL.
`ifndef THERMAL_PIXEL_RADIOMETRIC_MAP_MACROS_SVH
`define THERMAL_PIXEL_RADIOMETRIC_MAP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define TPRM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TPRM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tprm_pkg.sv
// Shared constants and types of the thermal radiometric map.
package tprm_pkg;

    localparam int GRAY_STEPS_DEF = 256;
    localparam int TEMP_STEPS_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_GRAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GRAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_TEMP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = 3'd5;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam int FRAC_W   = 8;
    localparam int VAL_W    = 32;
    localparam int DIST_W   = 17;
    localparam int WGT_W    = 25;
    localparam int WSUM_W   = 27;
    localparam int PROD_W   = 58;
    localparam int PSUM_W   = 59;
    localparam int SUM_W    = 60;
    localparam int QOUT_W   = 32;

    // Inverse distance weights are 2^24 / d.
    localparam logic [WGT_W-1:0] WGT_NUM = 25'h100_0000;

    typedef struct packed {
        logic             valid;
        logic             is_write;
        logic [7:0]       row;
        logic [3:0]       col;
        logic [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                      res;
        logic                      hit;
        logic [3:0][VAL_W-1:0]     v;
    } corner_t;

    typedef struct packed {
        logic             res;
        logic             hit;
        logic             neg;
        logic [VAL_W-1:0] v0;
    } final_t;

endpackage

// File: design/thermal_pixel_radiometric_map.sv
// Top level: raw thermal pixel to temperature through a 2-D calibration table.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | req_type, pixel, table_row, table_col, value
//  out     | out_valid/out_stall| temperature
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// One request per cycle while in_stall is low. Each pixel passes through three
// bit-serial dividers (index scaling, weights, final normalization) on its
// way to the output register.
// Reset clears control state only; table entries are undefined until written.
// A result waiting in the output register does not stop the pipeline; a skid
// entry takes one more, and in_stall is raised only while the skid is full.
`include "thermal_pixel_radiometric_map_macros.svh"

module thermal_pixel_radiometric_map #(
    parameter int GRAY_STEPS = tprm_pkg::GRAY_STEPS_DEF,
    parameter int TEMP_STEPS = tprm_pkg::TEMP_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [15:0]                     pixel,
    input  logic [7:0]                      table_row,
    input  logic [3:0]                      table_col,
    input  logic [31:0]                     table_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     temperature,
    input  logic                            cfg_we,
    input  logic [tprm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tprm_pkg::CFG_W-1:0]      cfg_data
);

    import tprm_pkg::*;

    localparam int MAX_STEPS  = (GRAY_STEPS > TEMP_STEPS) ? GRAY_STEPS : TEMP_STEPS;
    localparam int QGW        = $clog2((GRAY_STEPS - 1) * 256 + 1);
    localparam int QTW        = $clog2((TEMP_STEPS - 1) * 256 + 1);
    localparam int QIW        = $clog2((MAX_STEPS - 1) * 256 + 1);
    localparam int NIW        = 16 + QIW;
    localparam int RWI        = QGW - FRAC_W;
    localparam int CWI        = QTW - FRAC_W;
    localparam int GMUL       = (GRAY_STEPS - 1) * 256;
    localparam int TMUL       = (TEMP_STEPS - 1) * 256;
    localparam int GH         = (GRAY_STEPS + 1) / 2;
    localparam int TH         = (TEMP_STEPS + 1) / 2;
    localparam int BANK_DEPTH = GH * TH;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // ---------------- configuration ----------------
    logic [15:0]        min_gray_reg;
    logic [15:0]        max_gray_reg;
    logic signed [15:0] min_temp_reg;
    logic signed [15:0] max_temp_reg;
    logic signed [15:0] sensor_temp_reg;
    logic               interpolate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gray_reg    <= 16'd0;
            max_gray_reg    <= 16'hFFFF;
            min_temp_reg    <= 16'sd0;
            max_temp_reg    <= 16'sd12800;
            sensor_temp_reg <= 16'sd0;
            interpolate_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_GRAY:    min_gray_reg    <= cfg_data;
                REG_MAX_GRAY:    max_gray_reg    <= cfg_data;
                REG_MIN_TEMP:    min_temp_reg    <= cfg_data;
                REG_MAX_TEMP:    max_temp_reg    <= cfg_data;
                REG_SENSOR_TEMP: sensor_temp_reg <= cfg_data;
                REG_INTERPOLATE: interpolate_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // ---------------- stage 0: input register ----------------
    logic        s0_valid_reg;
    logic        s0_type_reg;
    logic [15:0] s0_pixel_reg;
    logic [7:0]  s0_row_reg;
    logic [3:0]  s0_col_reg;
    logic [31:0] s0_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_type_reg  <= req_type;
            s0_pixel_reg <= pixel;
            s0_row_reg   <= table_row;
            s0_col_reg   <= table_col;
            s0_value_reg <= table_value;
        end
    end

    // ---------------- stage 1: clamp and scale numerators ----------------
    logic               g_deg;
    logic [15:0]        g_x;
    logic [15:0]        g_diff;
    logic               t_deg;
    logic signed [15:0] t_x;
    logic [16:0]        t_diff;
    logic [16:0]        t_span;
    logic [NIW-1:0]     num_g_next;
    logic [15:0]        den_g_next;
    logic [NIW-1:0]     num_t_next;
    logic [15:0]        den_t_next;
    item_t              s1_item_next;

    always_comb
    begin
        g_deg = max_gray_reg <= min_gray_reg;
        if (s0_pixel_reg < min_gray_reg)
        begin
            g_x = min_gray_reg;
        end
        else if (s0_pixel_reg > max_gray_reg)
        begin
            g_x = max_gray_reg;
        end
        else
        begin
            g_x = s0_pixel_reg;
        end
        g_diff     = g_x - min_gray_reg;
        num_g_next = g_deg ? '0 : NIW'(g_diff) * NIW'(GMUL);
        den_g_next = g_deg ? 16'd1 : (max_gray_reg - min_gray_reg);

        t_deg = max_temp_reg <= min_temp_reg;
        if (sensor_temp_reg < min_temp_reg)
        begin
            t_x = min_temp_reg;
        end
        else if (sensor_temp_reg > max_temp_reg)
        begin
            t_x = max_temp_reg;
        end
        else
        begin
            t_x = sensor_temp_reg;
        end
        t_diff     = {t_x[15], t_x} - {min_temp_reg[15], min_temp_reg};
        t_span     = {max_temp_reg[15], max_temp_reg} - {min_temp_reg[15], min_temp_reg};
        num_t_next = t_deg ? '0 : NIW'(t_diff[15:0]) * NIW'(TMUL);
        den_t_next = t_deg ? 16'd1 : t_span[15:0];

        s1_item_next.valid    = s0_valid_reg;
        s1_item_next.is_write = (s0_type_reg == REQ_WRITE);
        s1_item_next.row      = s0_row_reg;
        s1_item_next.col      = s0_col_reg;
        s1_item_next.value    = s0_value_reg;
    end

    logic [NIW-1:0] s1_num_g_reg;
    logic [15:0]    s1_den_g_reg;
    logic [NIW-1:0] s1_num_t_reg;
    logic [15:0]    s1_den_t_reg;
    item_t          s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
        end
        else if (en)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_num_g_reg <= num_g_next;
            s1_den_g_reg <= den_g_next;
            s1_num_t_reg <= num_t_next;
            s1_den_t_reg <= den_t_next;
        end
    end

    // ---------------- index division ----------------
    logic [QIW-1:0] gi_q;
    logic [QIW-1:0] ti_q;
    item_t          d1_item;

    tprm_div #(.NW(NIW), .DW(16), .QW(QIW)) u_div_gray (
        .clk (clk),
        .en  (en),
        .num (s1_num_g_reg),
        .den (s1_den_g_reg),
        .quo (gi_q)
    );

    tprm_div #(.NW(NIW), .DW(16), .QW(QIW)) u_div_temp (
        .clk (clk),
        .en  (en),
        .num (s1_num_t_reg),
        .den (s1_den_t_reg),
        .quo (ti_q)
    );

    tprm_dly #(.W($bits(item_t)), .N(QIW)) u_dly_item (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (s1_item_reg),
        .dout  (d1_item)
    );

    // ---------------- stage 2: corners, distances, addresses ----------------
    logic [QGW-1:0]    gi;
    logic [QTW-1:0]    ti;
    logic [7:0]        fg;
    logic [7:0]        ft;
    logic [7:0]        dg1;
    logic [7:0]        dt1;
    logic [QGW:0]      g_rnd_w;
    logic [QTW:0]      t_rnd_w;
    logic [RWI-1:0]    g0;
    logic [RWI-1:0]    g1;
    logic [CWI-1:0]    t0;
    logic [CWI-1:0]    t1;
    logic [15:0]       sq_g0;
    logic [15:0]       sq_g1;
    logic [15:0]       sq_t0;
    logic [15:0]       sq_t1;
    logic [DIST_W-1:0] d_next [4];
    logic [AW-1:0]     raddr_next [4];
    logic [AW-1:0]     waddr_next;
    logic              wr_ok;
    logic [3:0]        we_next;
    logic              hit_next;
    logic              res_next;

    always_comb
    begin
        gi      = gi_q[QGW-1:0];
        ti      = ti_q[QTW-1:0];
        fg      = gi[FRAC_W-1:0];
        ft      = ti[FRAC_W-1:0];
        g_rnd_w = (QGW+1)'(gi) + (QGW+1)'(128);
        t_rnd_w = (QTW+1)'(ti) + (QTW+1)'(128);

        if (interpolate_reg)
        begin
            g0       = gi[QGW-1:FRAC_W];
            g1       = gi[QGW-1:FRAC_W] + RWI'(fg != 8'd0);
            t0       = ti[QTW-1:FRAC_W];
            t1       = ti[QTW-1:FRAC_W] + CWI'(ft != 8'd0);
            hit_next = (fg == 8'd0) && (ft == 8'd0);
        end
        else
        begin
            g0       = g_rnd_w[QGW-1:FRAC_W];
            g1       = g_rnd_w[QGW-1:FRAC_W];
            t0       = t_rnd_w[QTW-1:FRAC_W];
            t1       = t_rnd_w[QTW-1:FRAC_W];
            hit_next = 1'b1;
        end

        // Distance to the high corner is 256 - f, which wraps to zero for f = 0.
        dg1   = 8'd0 - fg;
        dt1   = 8'd0 - ft;
        sq_g0 = 16'(fg) * 16'(fg);
        sq_g1 = 16'(dg1) * 16'(dg1);
        sq_t0 = 16'(ft) * 16'(ft);
        sq_t1 = 16'(dt1) * 16'(dt1);
        d_next[0] = DIST_W'(sq_g0) + DIST_W'(sq_t0);
        d_next[1] = DIST_W'(sq_g0) + DIST_W'(sq_t1);
        d_next[2] = DIST_W'(sq_g1) + DIST_W'(sq_t0);
        d_next[3] = DIST_W'(sq_g1) + DIST_W'(sq_t1);

        // Bank b holds rows of parity b[1] and columns of parity b[0].
        for (int b = 0; b < 4; b++)
        begin
            raddr_next[b] = AW'(
                32'(((g0[0] == b[1]) ? g0 : g1) >> 1) * 32'(TH)
                + 32'(((t0[0] == b[0]) ? t0 : t1) >> 1));
        end

        waddr_next = AW'(32'(d1_item.row[7:1]) * 32'(TH) + 32'(d1_item.col[3:1]));
        wr_ok      = d1_item.valid && d1_item.is_write
                     && (32'(d1_item.row) < 32'(GRAY_STEPS))
                     && (32'(d1_item.col) < 32'(TEMP_STEPS));
        for (int b = 0; b < 4; b++)
        begin
            we_next[b] = wr_ok && ({d1_item.row[0], d1_item.col[0]} == 2'(b));
        end
        res_next = d1_item.valid && !d1_item.is_write;
    end

    logic [AW-1:0]     s2_raddr_reg [4];
    logic [AW-1:0]     s2_waddr_reg;
    logic [VAL_W-1:0]  s2_wdata_reg;
    logic [3:0]        s2_we_reg;
    logic [DIST_W-1:0] s2_d_reg [4];
    logic [1:0]        s2_gb_reg;
    logic [1:0]        s2_tb_reg;
    logic              s2_hit_reg;
    logic              s2_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_we_reg  <= '0;
            s2_res_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_we_reg  <= we_next;
            s2_res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int b = 0; b < 4; b++)
            begin
                s2_raddr_reg[b] <= raddr_next[b];
                s2_d_reg[b]     <= d_next[b];
            end
            s2_waddr_reg <= waddr_next;
            s2_wdata_reg <= d1_item.value;
            s2_gb_reg    <= {g1[0], g0[0]};
            s2_tb_reg    <= {t1[0], t0[0]};
            s2_hit_reg   <= hit_next;
        end
    end

    // ---------------- table banks and weight dividers ----------------
    logic [VAL_W-1:0] bank_rdata [4];
    logic [WGT_W-1:0] wgt [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        tprm_ram #(.WIDTH(VAL_W), .DEPTH(BANK_DEPTH), .AW(AW)) u_ram (
            .clk   (clk),
            .we    (s2_we_reg[b] && en),
            .waddr (s2_waddr_reg),
            .wdata (s2_wdata_reg),
            .re    (en),
            .raddr (s2_raddr_reg[b]),
            .rdata (bank_rdata[b])
        );

        tprm_div #(.NW(WGT_W), .DW(DIST_W), .QW(WGT_W)) u_div_wgt (
            .clk (clk),
            .en  (en),
            .num (WGT_NUM),
            .den (s2_d_reg[b]),
            .quo (wgt[b])
        );
    end

    // ---------------- stage 3: corner select ----------------
    logic       s3_res_reg;
    logic       s3_hit_reg;
    logic [1:0] s3_gb_reg;
    logic [1:0] s3_tb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_res_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_res_reg <= s2_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_hit_reg <= s2_hit_reg;
            s3_gb_reg  <= s2_gb_reg;
            s3_tb_reg  <= s2_tb_reg;
        end
    end

    corner_t s3_corner;
    corner_t d3_corner;

    always_comb
    begin
        s3_corner.res = s3_res_reg;
        s3_corner.hit = s3_hit_reg;
        for (int k = 0; k < 4; k++)
        begin
            s3_corner.v[k] = bank_rdata[{s3_gb_reg[k/2], s3_tb_reg[k%2]}];
        end
    end

    tprm_dly #(.W($bits(corner_t)), .N(WGT_W - 1)) u_dly_corner (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (s3_corner),
        .dout  (d3_corner)
    );

    // ---------------- stage 4: weighted products ----------------
    logic signed [PROD_W-1:0] s4_prod_reg [4];
    logic [WSUM_W-1:0]        s4_wsum_reg;
    final_t                   s4_side_reg;
    final_t                   s4_side_next;

    always_comb
    begin
        s4_side_next.res = d3_corner.res;
        s4_side_next.hit = d3_corner.hit;
        s4_side_next.neg = 1'b0;
        s4_side_next.v0  = d3_corner.v[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s4_prod_reg[k] <= $signed(d3_corner.v[k]) * $signed({1'b0, wgt[k]});
            end
            s4_wsum_reg <= WSUM_W'(wgt[0]) + WSUM_W'(wgt[1])
                           + WSUM_W'(wgt[2]) + WSUM_W'(wgt[3]);
        end
    end

    // ---------------- stage 5: pair sums ----------------
    logic signed [PSUM_W-1:0] s5_s01_reg;
    logic signed [PSUM_W-1:0] s5_s23_reg;
    logic [WSUM_W-1:0]        s5_wsum_reg;
    final_t                   s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_s01_reg  <= PSUM_W'(s4_prod_reg[0]) + PSUM_W'(s4_prod_reg[1]);
            s5_s23_reg  <= PSUM_W'(s4_prod_reg[2]) + PSUM_W'(s4_prod_reg[3]);
            s5_wsum_reg <= s4_wsum_reg;
        end
    end

    // ---------------- stage 6: total plus half weight for rounding ----------------
    logic [SUM_W-1:0]  s6_num_reg;
    logic [SUM_W-1:0]  s6_num_next;
    logic [WSUM_W-1:0] s6_wsum_reg;
    final_t            s6_side_reg;
    final_t            s6_side_next;

    always_comb
    begin
        s6_num_next      = SUM_W'(s5_s01_reg) + SUM_W'(s5_s23_reg) + SUM_W'(s5_wsum_reg >> 1);
        s6_side_next     = s5_side_reg;
        s6_side_next.neg = s6_num_next[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_num_reg  <= s6_num_next;
            s6_wsum_reg <= s5_wsum_reg;
        end
    end

    // ---------------- stage 7: magnitude for floor division ----------------
    // A negative total divides as -((W - 1 - num) / W), which floors.
    logic [SUM_W-1:0]  s7_a_reg;
    logic [WSUM_W-1:0] s7_wsum_reg;
    final_t            s7_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_a_reg    <= s6_side_reg.neg
                           ? (SUM_W'(s6_wsum_reg) - s6_num_reg - SUM_W'(1))
                           : s6_num_reg;
            s7_wsum_reg <= s6_wsum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_side_reg <= '0;
            s5_side_reg <= '0;
            s6_side_reg <= '0;
            s7_side_reg <= '0;
        end
        else if (en)
        begin
            s4_side_reg <= s4_side_next;
            s5_side_reg <= s4_side_reg;
            s6_side_reg <= s6_side_next;
            s7_side_reg <= s6_side_reg;
        end
    end

    // ---------------- final division ----------------
    logic [QOUT_W-1:0] quo_out;
    final_t            fin;

    tprm_div #(.NW(SUM_W), .DW(WSUM_W), .QW(QOUT_W)) u_div_out (
        .clk (clk),
        .en  (en),
        .num (s7_a_reg),
        .den (s7_wsum_reg),
        .quo (quo_out)
    );

    tprm_dly #(.W($bits(final_t)), .N(QOUT_W)) u_dly_final (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (s7_side_reg),
        .dout  (fin)
    );

    logic [VAL_W-1:0] res_value;
    logic             last_fire;

    assign res_value = fin.hit ? fin.v0 : (fin.neg ? (VAL_W'(0) - quo_out) : quo_out);
    assign last_fire = en && fin.res;

    // ---------------- output register and skid ----------------
    logic             out_valid_reg;
    logic [VAL_W-1:0] temp_reg;
    logic [VAL_W-1:0] skid_data_reg;
    logic             out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (last_fire)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                temp_reg <= skid_data_reg;
            end
        end
        else if (last_fire)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= res_value;
            end
            else
            begin
                temp_reg <= res_value;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temp_reg;

    // ---------------- assertions ----------------
    `TPRM_ASSERT_IMPL(a_skid_has_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    `TPRM_ASSERT_NEXT(a_skid_fill, out_valid_reg && out_stall && !skid_valid_reg && last_fire, skid_valid_reg && out_valid_reg, "stalled result lost")
    `TPRM_ASSERT_NEXT(a_skid_hold, skid_valid_reg && out_stall, skid_valid_reg && $stable(skid_data_reg), "skid entry changed while stalled")
    `TPRM_ASSERT_ALWAYS(a_one_bank_write, $onehot0(s2_we_reg), "table write hits more than one bank")

endmodule

// File: design/tprm_ram.sv
// Generic single write, single registered read RAM.
module tprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tprm_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module tprm_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int EW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_s [QW];
    logic [DW-1:0] den_s [QW];
    logic [QW-1:0] quo_s [QW+1];

    assign rem_s[0] = num;
    assign den_s[0] = den;
    assign quo_s[0] = '0;

    // Stage k settles quotient bit QW-1-k; the quotient must fit in QW bits.
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [EW-1:0] shifted;
        logic          take;
        logic [QW-1:0] quo_reg;

        assign shifted = EW'(den_s[k]) << (QW - 1 - k);
        assign take    = EW'(rem_s[k]) >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg <= quo_s[k] | (take ? (QW'(1) << (QW - 1 - k)) : '0);
            end
        end
        assign quo_s[k+1] = quo_reg;

        if (k < QW - 1)
        begin : g_carry
            logic [NW-1:0] rem_reg;
            logic [DW-1:0] den_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= take ? NW'(EW'(rem_s[k]) - shifted) : rem_s[k];
                    den_reg <= den_s[k];
                end
            end
            assign rem_s[k+1] = rem_reg;
            assign den_s[k+1] = den_reg;
        end
    end

    assign quo = quo_s[QW];

endmodule

// File: design/tprm_dly.sv
// Delay line that keeps side data aligned with a pipelined unit.
module tprm_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

// File: tb/thermal_pixel_radiometric_map_test.sv
// Self-checking testbench of the thermal pixel radiometric map.
module thermal_pixel_radiometric_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tprm_pkg::*;

    localparam int GSTEPS = GRAY_STEPS_DEF;
    localparam int TSTEPS = TEMP_STEPS_DEF;
    localparam int SETTLE = 120;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES = 24;
    localparam int PHASE_REQS = 72;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [15:0] pixel;
    logic [7:0]  table_row;
    logic [3:0]  table_col;
    logic [31:0] table_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] temperature;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    thermal_pixel_radiometric_map uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pixel(pixel), .table_row(table_row),
        .table_col(table_col), .table_value(table_value),
        .out_valid(out_valid), .out_stall(out_stall), .temperature(temperature),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the calibration table and the registers.
    logic [31:0] cal_table [GSTEPS*TSTEPS];
    logic [15:0] gray_lo, gray_hi;
    logic signed [15:0] temp_lo, temp_hi, thermistor;
    logic        blend_mode;

    logic [31:0] temp_queue[$];
    int cycles, errors, pixels_checked, writes_sent, burst_left, stall_mode;

    typedef struct {
        logic        is_write;
        logic [15:0] pix;
        logic [7:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        typed;
        logic [31:0] want;
    } directed_row_t;

    directed_row_t directed[] = '{
        '{REQ_WRITE, 16'd0, 8'd0, 4'd0, 32'h7fff_ffff, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'd0, 8'd0, 4'd0, 32'd0, 1'b1, 32'h7fff_ffff},
        '{REQ_WRITE, 16'd0, 8'd255, 4'd0, 32'h8000_0000, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'hffff, 8'd0, 4'd0, 32'd0, 1'b1, 32'h8000_0000},
        '{REQ_WRITE, 16'd0, 8'd255, 4'd15, 32'h0000_0000, 1'b0, 32'd0},
        '{REQ_WRITE, 16'd0, 8'd1, 4'd0, 32'hffff_ffff, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'd256, 8'd0, 4'd0, 32'd0, 1'b1, 32'hffff_ffff},
        '{REQ_PIXEL, 16'd127, 8'd0, 4'd0, 32'd0, 1'b1, 32'h7fff_ffff},
        '{REQ_PIXEL, 16'd128, 8'd0, 4'd0, 32'd0, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'h8000, 8'd0, 4'd0, 32'd0, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'h7fff, 8'd0, 4'd0, 32'd0, 1'b0, 32'd0},
        '{REQ_WRITE, 16'hffff, 8'd128, 4'd8, 32'h5555_aaaa, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'hfffe, 8'd0, 4'd0, 32'd0, 1'b0, 32'd0},
        '{REQ_PIXEL, 16'h0001, 8'd0, 4'd0, 32'd0, 1'b0, 32'd0}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Fractional table index with 8 fraction bits.
    function automatic int unsigned frac_index(longint x, longint lo, longint hi, int steps);
        if (hi <= lo)
            return 0;
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        return int'(((x - lo) * (steps - 1) * 256) / (hi - lo));
    endfunction

    function automatic longint corner(int unsigned g, int unsigned t);
        return longint'($signed(cal_table[g*TSTEPS + t]));
    endfunction

    function automatic logic [31:0] map_temperature(logic [15:0] raw);
        int unsigned gi, ti, fg, ft, g0, g1, t0, t1, dg0, dg1, dt0, dt1;
        int unsigned dsq [4];
        longint v [4];
        longint num, wsum, w, q;
        gi = frac_index(longint'(raw), longint'(gray_lo), longint'(gray_hi), GSTEPS);
        ti = frac_index(longint'(thermistor), longint'(temp_lo), longint'(temp_hi), TSTEPS);
        if (!blend_mode)
            return cal_table[((gi + 128) >> 8)*TSTEPS + ((ti + 128) >> 8)];
        fg = gi & 255;
        ft = ti & 255;
        g0 = gi >> 8;
        t0 = ti >> 8;
        g1 = g0 + (fg != 0);
        t1 = t0 + (ft != 0);
        dg0 = fg;
        dg1 = (fg != 0) ? 256 - fg : 0;
        dt0 = ft;
        dt1 = (ft != 0) ? 256 - ft : 0;
        dsq[0] = dg0*dg0 + dt0*dt0;
        dsq[1] = dg0*dg0 + dt1*dt1;
        dsq[2] = dg1*dg1 + dt0*dt0;
        dsq[3] = dg1*dg1 + dt1*dt1;
        v[0] = corner(g0, t0);
        v[1] = corner(g0, t1);
        v[2] = corner(g1, t0);
        v[3] = corner(g1, t1);
        // An exact hit on a grid point returns that corner unweighted.
        for (int k = 0; k < 4; k++)
            if (dsq[k] == 0)
                return v[k][31:0];
        num = 0;
        wsum = 0;
        for (int k = 0; k < 4; k++)
        begin
            w = longint'((32'd1 << 24) / dsq[k]);
            num += v[k] * w;
            wsum += w;
        end
        num += wsum / 2;
        q = (num >= 0) ? num / wsum : -((-num + wsum - 1) / wsum);
        return q[31:0];
    endfunction

    // Drive one request, honoring the burst and gap pattern of the sender.
    task automatic send_request(logic is_write, logic [15:0] pix, logic [7:0] row,
                                logic [3:0] col, logic [31:0] value,
                                logic typed, logic [31:0] want);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= is_write;
        pixel <= pix;
        table_row <= row;
        table_col <= col;
        table_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        if (is_write)
        begin
            cal_table[row*TSTEPS + col] = value;
            writes_sent++;
        end
        else
            temp_queue.push_back(typed ? want : map_temperature(pix));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        wait (temp_queue.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_registers(logic [15:0] glo, logic [15:0] ghi, logic [15:0] tlo,
                                  logic [15:0] thi, logic [15:0] sens, logic blend);
        logic [15:0] vals [6];
        vals = '{glo, ghi, tlo, thi, sens, {15'd0, blend}};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        gray_lo = glo;
        gray_hi = ghi;
        temp_lo = tlo;
        temp_hi = thi;
        thermistor = sens;
        blend_mode = blend;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 4000)) - 2000);
            default: return $urandom;
        endcase
    endfunction

    // Checker and stall pattern of the result side.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (temp_queue.size() == 0)
            begin
                $error("temperature: unexpected result %h", temperature);
                errors++;
            end
            else
            begin
                if (temperature !== temp_queue[0])
                begin
                    $error("temperature: expected %h, actual %h", temp_queue[0], temperature);
                    errors++;
                end
                void'(temp_queue.pop_front());
                pixels_checked++;
            end
        end
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial
    begin
        logic [15:0] glo, ghi, tlo, thi, sens, pix;
        int span, kind;
        cycles = 0;
        errors = 0;
        pixels_checked = 0;
        writes_sent = 0;
        burst_left = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_PIXEL;
        pixel = '0;
        table_row = '0;
        table_col = '0;
        table_value = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gray_lo = 16'd0;
        gray_hi = 16'hffff;
        temp_lo = 16'sd0;
        temp_hi = 16'sd12800;
        thermistor = 16'sd0;
        blend_mode = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every entry is written before any pixel may read it.
        for (int a = 0; a < GSTEPS*TSTEPS; a++)
            send_request(REQ_WRITE, 16'($urandom), 8'(a / TSTEPS), 4'(a % TSTEPS),
                         random_value(), 1'b0, 32'd0);

        foreach (directed[i])
            send_request(directed[i].is_write, directed[i].pix, directed[i].row,
                         directed[i].col, directed[i].value, directed[i].typed,
                         directed[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            kind = (p / 2) % 6;
            glo = 16'($urandom);
            ghi = 16'($urandom);
            tlo = 16'($urandom);
            thi = 16'($urandom);
            sens = 16'($urandom);
            case (kind)
                0:
                begin
                    glo = 16'd0;
                    ghi = 16'hffff;
                    tlo = 16'h8000;
                    thi = 16'h7fff;
                end
                1:
                begin
                    ghi = glo;
                    thi = tlo;
                end
                2:
                begin
                    if (glo < ghi)
                        {glo, ghi} = {ghi, glo};
                    if ($signed(tlo) < $signed(thi))
                        {tlo, thi} = {thi, tlo};
                end
                3:
                begin
                    // Ranges that put whole grid steps on integers give exact hits.
                    span = 255 * $urandom_range(1, 200);
                    glo = 16'($urandom_range(0, 65535 - span));
                    ghi = glo + 16'(span);
                    tlo = 16'($signed(16'($urandom_range(0, 20000))) - 16'sd10000);
                    thi = tlo + 16'(15 * 100);
                    sens = tlo + 16'(100 * $urandom_range(0, 15));
                end
                4:
                begin
                    tlo = 16'h8000 + 16'($urandom_range(0, 100));
                    thi = 16'h7fff - 16'($urandom_range(0, 100));
                    sens = p[2] ? 16'h8000 : 16'h7fff;
                end
                default: ;
            endcase
            load_registers(glo, ghi, tlo, thi, sens, p[0]);

            for (int n = 0; n < PHASE_REQS; n++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                    begin
                        send_request(REQ_WRITE, 16'($urandom), 8'($urandom), 4'($urandom),
                                     random_value(), 1'b0, 32'd0);
                        continue;
                    end
                    3, 4:
                    begin
                        case ($urandom_range(0, 3))
                            0: pix = 16'd0;
                            1: pix = 16'hffff;
                            2: pix = gray_lo;
                            default: pix = gray_hi;
                        endcase
                    end
                    5, 6, 7:
                        pix = gray_lo + 16'((int'(gray_hi - gray_lo) * $urandom_range(0, 255))
                                            / 255);
                    8, 9:
                        pix = 16'($urandom);
                    default:
                        pix = (gray_hi >= gray_lo) ? 16'($urandom_range(gray_lo, gray_hi))
                                                   : 16'($urandom);
                endcase
                send_request(REQ_PIXEL, pix, 8'($urandom), 4'($urandom), 32'($urandom),
                             1'b0, 32'd0);
            end
            drain();
        end

        $display("Checked %0d converted pixels and %0d table writes over %0d register settings.",
                 pixels_checked, writes_sent, NUM_PHASES + 1);
        $display("Settings covered full, collapsed, inverted and grid-aligned ranges, both modes.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/tprm_pkg.sv
design/tprm_ram.sv
design/tprm_div.sv
design/tprm_dly.sv
design/thermal_pixel_radiometric_map.sv
tb/thermal_pixel_radiometric_map_test.sv
